FILE: hw/rtl/pnad_pkg.sv
// Shared types, widths and constants for the plane normal angle deviation unit.
// Holds the arctangent table and the stage structures passed between cells.
// No dependencies.
package pnad_pkg;

   localparam int VecBits     = 20;
   localparam int VecLimit    = 1 << 18;
   localparam int NormBits    = 57;
   localparam int AngBits     = 30;
   localparam int SqrtSteps   = 32;
   localparam int CordicSteps = 31;
   localparam int CordW       = 36;
   localparam int ZW          = 34;
   localparam logic [30:0] HalfPiQ30 = 31'h6487ED51;

   typedef struct packed {
      logic valid;
      logic degen;
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [63:0]         rem;
      logic [63:0]         root;
      logic [AngBits-1:0]  y;
   } sqrt_stage_type;

   typedef struct packed {
      tag_type                  tag;
      logic signed [CordW-1:0]  x;
      logic signed [CordW-1:0]  y;
      logic signed [ZW-1:0]     z;
   } cordic_stage_type;

   function automatic logic [31:0] atan_q30(input int step);
      logic [31:0] r;
      case (step)
         0: r = 32'h3243F6A8;
         1: r = 32'h1DAC6705;
         2: r = 32'h0FADBAFC;
         3: r = 32'h07F56EA6;
         4: r = 32'h03FEAB76;
         5: r = 32'h01FFD55B;
         6: r = 32'h00FFFAAA;
         7: r = 32'h007FFF55;
         8: r = 32'h003FFFEA;
         9: r = 32'h001FFFFD;
         10: r = 32'h000FFFFF;
         11: r = 32'h0007FFFF;
         12: r = 32'h0003FFFF;
         13: r = 32'h0001FFFF;
         14: r = 32'h0000FFFF;
         15: r = 32'h00007FFF;
         16: r = 32'h00003FFF;
         17: r = 32'h00001FFF;
         18: r = 32'h00000FFF;
         19: r = 32'h000007FF;
         20: r = 32'h000003FF;
         21: r = 32'h000001FF;
         22: r = 32'h000000FF;
         23: r = 32'h0000007F;
         24: r = 32'h0000003F;
         25: r = 32'h0000001F;
         26: r = 32'h0000000F;
         27: r = 32'h00000008;
         28: r = 32'h00000004;
         29: r = 32'h00000002;
         30: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/pnad_req_if.sv
// Request channel interface: four points per transaction.
// No dependencies.
interface pnad_req_if #(parameter int COORD_BITS = 18) ();
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] center_z;
   logic signed [COORD_BITS-1:0] first_nb_x;
   logic signed [COORD_BITS-1:0] first_nb_y;
   logic signed [COORD_BITS-1:0] first_nb_z;
   logic signed [COORD_BITS-1:0] second_nb_x;
   logic signed [COORD_BITS-1:0] second_nb_y;
   logic signed [COORD_BITS-1:0] second_nb_z;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   logic signed [COORD_BITS-1:0] target_z;

   modport source (output valid, center_x, center_y, center_z, first_nb_x, first_nb_y,
                   first_nb_z, second_nb_x, second_nb_y, second_nb_z, target_x, target_y,
                   target_z, input ready);
   modport sink (input valid, center_x, center_y, center_z, first_nb_x, first_nb_y,
                 first_nb_z, second_nb_x, second_nb_y, second_nb_z, target_x, target_y,
                 target_z, output ready);
endinterface

FILE: hw/rtl/pnad_rsp_if.sv
// Response channel interface: deviation angle and degenerate flag.
// No dependencies.
interface pnad_rsp_if #(parameter int ANGLE_FRAC_BITS = 16) ();
   logic valid;
   logic ready;
   logic [ANGLE_FRAC_BITS:0] deviation;
   logic degenerate;

   modport source (output valid, deviation, degenerate, input ready);
   modport sink (input valid, deviation, degenerate, output ready);
endinterface

FILE: hw/rtl/pnad_sqrt_cell.sv
// One digit step of the pipelined integer square root.
// Depends on pnad_pkg.
module pnad_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  pnad_pkg::sqrt_stage_type  stage_in,
   output pnad_pkg::sqrt_stage_type  stage_out
);

   localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

   pnad_pkg::sqrt_stage_type stage_ff, stage_in_c;
   logic [63:0] trial;

   always_comb begin
      trial = stage_in.root + Bit;
      stage_in_c = stage_in;
      if (stage_in.rem >= trial) begin
         stage_in_c.rem  = stage_in.rem - trial;
         stage_in_c.root = (stage_in.root >> 1) + Bit;
      end else begin
         stage_in_c.root = stage_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: hw/rtl/pnad_cordic_cell.sv
// One vectoring rotation of the pipelined arctangent.
// Depends on pnad_pkg.
module pnad_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  pnad_pkg::cordic_stage_type  stage_in,
   output pnad_pkg::cordic_stage_type  stage_out
);

   localparam logic signed [pnad_pkg::ZW-1:0] Atan =
      $signed({2'b00, pnad_pkg::atan_q30(STEP)});

   pnad_pkg::cordic_stage_type stage_ff, stage_in_c;
   logic signed [pnad_pkg::CordW-1:0] dx, dy;

   always_comb begin
      dx = stage_in.y >>> STEP;
      dy = stage_in.x >>> STEP;
      stage_in_c = stage_in;
      if (!stage_in.y[pnad_pkg::CordW-1]) begin
         stage_in_c.x = stage_in.x + dx;
         stage_in_c.y = stage_in.y - dy;
         stage_in_c.z = stage_in.z + Atan;
      end else begin
         stage_in_c.x = stage_in.x - dx;
         stage_in_c.y = stage_in.y + dy;
         stage_in_c.z = stage_in.z - Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: hw/rtl/plane_normal_angle_deviation_unit.sv
// Top level of the plane normal angle deviation unit.
// Depends on pnad_pkg, pnad_req_if, pnad_rsp_if, pnad_sqrt_cell, pnad_cordic_cell.
//
// Each request transaction carries a center, two neighbors and a target point.
// The unit forms the plane normal from the neighbor offsets and returns how far
// the angle between that normal and the center-to-target vector lies from
// ninety degrees, in units of 2^-ANGLE_FRAC_BITS radian, with a degenerate flag
// when the normal or the target vector has zero length.
// The datapath is a fixed pipeline: 13 stages of vector algebra and
// normalization, 32 square root cells, 31 arctangent cells and the response
// register, 77 registers in all. One request is accepted per cycle while the
// pipeline is not held. The whole pipeline advances together;
// when the response register holds a result that the receiver does not take,
// every stage holds and req ready stays low until the response is taken.
// Synchronous reset clears all valid bits; no other state is needed.
module plane_normal_angle_deviation_unit #(
   parameter int COORD_BITS      = 18,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   pnad_req_if.sink    req_bus,
   pnad_rsp_if.source  rsp_bus
);

   localparam int DW   = COORD_BITS + 1;
   localparam int MW   = (DW > 19) ? DW : 19;
   localparam int MaxS = MW - 19;
   localparam int OS   = 30 - ANGLE_FRAC_BITS;
   localparam int VB   = pnad_pkg::VecBits;

   logic adv;
   logic out_valid_ff;
   logic [ANGLE_FRAC_BITS:0] out_dev_ff;
   logic out_deg_ff;

   assign adv = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   pnad_pkg::tag_type t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff;
   pnad_pkg::tag_type t8_ff, t9_ff, t10_ff, t11_ff, t12_ff, t13_ff;

   // Stage 1: offsets from the center.
   logic signed [DW-1:0] u1_ff[3], w1_ff[3], v1_ff[3];
   logic signed [DW-1:0] cen[3], pa[3], pb[3], pt[3];

   assign cen[0] = DW'(req_bus.center_x);
   assign cen[1] = DW'(req_bus.center_y);
   assign cen[2] = DW'(req_bus.center_z);
   assign pa[0]  = DW'(req_bus.first_nb_x);
   assign pa[1]  = DW'(req_bus.first_nb_y);
   assign pa[2]  = DW'(req_bus.first_nb_z);
   assign pb[0]  = DW'(req_bus.second_nb_x);
   assign pb[1]  = DW'(req_bus.second_nb_y);
   assign pb[2]  = DW'(req_bus.second_nb_z);
   assign pt[0]  = DW'(req_bus.target_x);
   assign pt[1]  = DW'(req_bus.target_y);
   assign pt[2]  = DW'(req_bus.target_z);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            u1_ff[k] <= pa[k] - cen[k];
            w1_ff[k] <= pb[k] - cen[k];
            v1_ff[k] <= pt[k] - cen[k];
         end
      end
   end

   // Stage 2: component magnitudes and per-vector maximum.
   logic [MW-1:0] mg2_ff[3][3];
   logic          sg2_ff[3][3];
   logic [MW-1:0] mx2_ff[3];
   logic [MW-1:0] mg2_in[3][3];
   logic [MW-1:0] mx2_in[3];
   logic signed [DW-1:0] vec1[3][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vec1[0][k] = u1_ff[k];
         vec1[1][k] = w1_ff[k];
         vec1[2][k] = v1_ff[k];
      end
      for (int j = 0; j < 3; j++) begin
         mx2_in[j] = '0;
         for (int k = 0; k < 3; k++) begin
            mg2_in[j][k] = vec1[j][k][DW-1] ? MW'(-vec1[j][k]) : MW'(vec1[j][k]);
            if (mg2_in[j][k] > mx2_in[j]) begin
               mx2_in[j] = mg2_in[j][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            mx2_ff[j] <= mx2_in[j];
            for (int k = 0; k < 3; k++) begin
               mg2_ff[j][k] <= mg2_in[j][k];
               sg2_ff[j][k] <= vec1[j][k][DW-1];
            end
         end
      end
   end

   // Stage 3: scale each vector so its largest component is at most 2^18.
   logic signed [VB-1:0] sc3_ff[3][3];
   logic signed [VB-1:0] sc3_in[3][3];
   logic                 vz3_ff;
   logic [MW-1:0]        shm[3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            shm[j][k] = mg2_ff[j][k];
         end
         for (int s = MaxS; s >= 0; s--) begin
            if ((mx2_ff[j] >> s) <= MW'(pnad_pkg::VecLimit)) begin
               for (int k = 0; k < 3; k++) begin
                  shm[j][k] = mg2_ff[j][k] >> s;
               end
            end
         end
         for (int k = 0; k < 3; k++) begin
            sc3_in[j][k] = sg2_ff[j][k] ? -$signed({1'b0, shm[j][k][18:0]})
                                        : $signed({1'b0, shm[j][k][18:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc3_ff <= sc3_in;
         vz3_ff <= (sc3_in[2][0] == '0) && (sc3_in[2][1] == '0) && (sc3_in[2][2] == '0);
      end
   end

   // Stage 4: partial products of the normal.
   logic signed [2*VB-1:0] p4_ff[6];
   logic signed [VB-1:0]   v4_ff[3];
   logic                   vz4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_ff[0] <= sc3_ff[0][1] * sc3_ff[1][2];
         p4_ff[1] <= sc3_ff[0][2] * sc3_ff[1][1];
         p4_ff[2] <= sc3_ff[0][2] * sc3_ff[1][0];
         p4_ff[3] <= sc3_ff[0][0] * sc3_ff[1][2];
         p4_ff[4] <= sc3_ff[0][0] * sc3_ff[1][1];
         p4_ff[5] <= sc3_ff[0][1] * sc3_ff[1][0];
         v4_ff    <= sc3_ff[2];
         vz4_ff   <= vz3_ff;
      end
   end

   // Stage 5: normal vector.
   localparam int NW = 39;
   logic signed [NW-1:0]   n5_ff[3];
   logic signed [NW-1:0]   n5_in[3];
   logic signed [2*VB:0]   nd[3];
   logic signed [VB-1:0]   v5_ff[3];
   logic                   deg5;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nd[k] = (2*VB+1)'(p4_ff[2*k]) - (2*VB+1)'(p4_ff[2*k+1]);
         n5_in[k] = nd[k][NW-1:0];
      end
      deg5 = vz4_ff || ((n5_in[0] == '0) && (n5_in[1] == '0) && (n5_in[2] == '0));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n5_ff <= n5_in;
         v5_ff <= v4_ff;
      end
   end

   // Stage 6: products for n x v and n . v.
   localparam int QW = NW + VB;
   logic signed [QW-1:0] q6_ff[9];

   always_ff @(posedge clock) begin
      if (adv) begin
         q6_ff[0] <= n5_ff[1] * v5_ff[2];
         q6_ff[1] <= n5_ff[2] * v5_ff[1];
         q6_ff[2] <= n5_ff[2] * v5_ff[0];
         q6_ff[3] <= n5_ff[0] * v5_ff[2];
         q6_ff[4] <= n5_ff[0] * v5_ff[1];
         q6_ff[5] <= n5_ff[1] * v5_ff[0];
         q6_ff[6] <= n5_ff[0] * v5_ff[0];
         q6_ff[7] <= n5_ff[1] * v5_ff[1];
         q6_ff[8] <= n5_ff[2] * v5_ff[2];
      end
   end

   // Stage 7: cross and dot products.
   localparam int CW = pnad_pkg::NormBits + 1;
   logic signed [CW-1:0]  c7_ff[4];
   logic signed [QW+1:0]  cs[4];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cs[k] = (QW+2)'(q6_ff[2*k]) - (QW+2)'(q6_ff[2*k+1]);
      end
      cs[3] = (QW+2)'(q6_ff[6]) + (QW+2)'(q6_ff[7]) + (QW+2)'(q6_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            c7_ff[k] <= cs[k][CW-1:0];
         end
      end
   end

   // Stage 8: magnitudes and their combined leading-one word.
   localparam int AW = pnad_pkg::NormBits;
   logic [AW-1:0] a8_ff[4];
   logic [AW-1:0] a8_in[4];
   logic [63:0]   ow8_ff;
   logic [AW-1:0] orw;

   always_comb begin
      orw = '0;
      for (int k = 0; k < 4; k++) begin
         a8_in[k] = c7_ff[k][CW-1] ? AW'(-c7_ff[k]) : AW'(c7_ff[k]);
         orw = orw | a8_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a8_ff  <= a8_in;
         ow8_ff <= 64'(orw);
      end
   end

   // Stage 9: byte-level occupancy of the leading-one word.
   logic [AW-1:0] a9_ff[4];
   logic [63:0]   ow9_ff;
   logic [7:0]    grp9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a9_ff  <= a8_ff;
         ow9_ff <= ow8_ff;
         for (int g = 0; g < 8; g++) begin
            grp9_ff[g] <= |ow8_ff[8*g +: 8];
         end
      end
   end

   // Stage 10: normalizing shift amount.
   logic [AW-1:0] a10_ff[4];
   logic [5:0]    sh10_ff;
   logic [2:0]    gsel, bsel;
   logic [7:0]    lead_byte;

   always_comb begin
      gsel = '0;
      bsel = '0;
      for (int g = 0; g < 8; g++) begin
         if (grp9_ff[g]) begin
            gsel = 3'(g);
         end
      end
      lead_byte = ow9_ff[{gsel, 3'b000} +: 8];
      for (int b = 0; b < 8; b++) begin
         if (lead_byte[b]) begin
            bsel = 3'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a10_ff  <= a9_ff;
         sh10_ff <= ~{gsel, bsel};
      end
   end

   // Stage 11: normalize so the largest magnitude has its top bit at 2^29.
   localparam int BW = pnad_pkg::AngBits;
   logic [BW-1:0] a11_ff[4];
   logic [63:0]   shv[4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         shv[k] = 64'(a10_ff[k]) << sh10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            a11_ff[k] <= shv[k][63:64-BW];
         end
      end
   end

   // Stage 12: squares. Stage 13: sum of squares.
   logic [2*BW-1:0] sq12_ff[3];
   logic [BW-1:0]   y12_ff, y13_ff;
   logic [63:0]     rsq13_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sq12_ff[k] <= a11_ff[k] * a11_ff[k];
         end
         y12_ff   <= a11_ff[3];
         rsq13_ff <= 64'(sq12_ff[0]) + 64'(sq12_ff[1]) + 64'(sq12_ff[2]);
         y13_ff   <= y12_ff;
      end
   end

   // Tag pipeline through the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid  <= 1'b0;
         t2_ff.valid  <= 1'b0;
         t3_ff.valid  <= 1'b0;
         t4_ff.valid  <= 1'b0;
         t5_ff.valid  <= 1'b0;
         t6_ff.valid  <= 1'b0;
         t7_ff.valid  <= 1'b0;
         t8_ff.valid  <= 1'b0;
         t9_ff.valid  <= 1'b0;
         t10_ff.valid <= 1'b0;
         t11_ff.valid <= 1'b0;
         t12_ff.valid <= 1'b0;
         t13_ff.valid <= 1'b0;
      end else if (adv) begin
         t1_ff  <= '{valid: req_bus.valid, degen: 1'b0};
         t2_ff  <= t1_ff;
         t3_ff  <= t2_ff;
         t4_ff  <= t3_ff;
         t5_ff  <= '{valid: t4_ff.valid, degen: deg5};
         t6_ff  <= t5_ff;
         t7_ff  <= t6_ff;
         t8_ff  <= t7_ff;
         t9_ff  <= t8_ff;
         t10_ff <= t9_ff;
         t11_ff <= t10_ff;
         t12_ff <= t11_ff;
         t13_ff <= t12_ff;
      end
   end

   // Square root chain.
   pnad_pkg::sqrt_stage_type sq_chain[pnad_pkg::SqrtSteps+1];

   assign sq_chain[0] = '{tag: t13_ff, rem: rsq13_ff, root: 64'd0, y: y13_ff};

   for (genvar i = 0; i < pnad_pkg::SqrtSteps; i++) begin : g_sqrt
      pnad_sqrt_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_in  (sq_chain[i]),
         .stage_out (sq_chain[i+1])
      );
   end

   // Arctangent chain.
   pnad_pkg::cordic_stage_type co_chain[pnad_pkg::CordicSteps+1];
   pnad_pkg::sqrt_stage_type   sq_last;

   assign sq_last = sq_chain[pnad_pkg::SqrtSteps];
   assign co_chain[0] = '{tag: sq_last.tag,
                          x: $signed({5'b00000, sq_last.root[30:0]}),
                          y: $signed({6'b000000, sq_last.y}),
                          z: '0};

   for (genvar i = 0; i < pnad_pkg::CordicSteps; i++) begin : g_cordic
      pnad_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_in  (co_chain[i]),
         .stage_out (co_chain[i+1])
      );
   end

   // Clamp, round and register the response.
   pnad_pkg::cordic_stage_type co_last;
   logic [30:0] zc;
   logic [31:0] zr;
   logic [ANGLE_FRAC_BITS:0] dev_in;

   assign co_last = co_chain[pnad_pkg::CordicSteps];

   always_comb begin
      if (co_last.z[pnad_pkg::ZW-1]) begin
         zc = '0;
      end else if (co_last.z > $signed({3'b000, pnad_pkg::HalfPiQ30})) begin
         zc = pnad_pkg::HalfPiQ30;
      end else begin
         zc = co_last.z[30:0];
      end
      zr = 32'(zc) + (32'd1 << (OS - 1));
      dev_in = co_last.tag.degen ? '0 : zr[OS+ANGLE_FRAC_BITS:OS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= co_last.tag.valid;
         out_dev_ff   <= dev_in;
         out_deg_ff   <= co_last.tag.degen;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.deviation  = out_dev_ff;
   assign rsp_bus.degenerate = out_deg_ff;

endmodule
